[rtl/core/swcl_pkg.sv]
// Shared types and constants for the spike window class likelihood block.
`default_nettype none
package swcl_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int MAX_WINDOWS = 256;
    localparam int MAX_CLASSES = 16;
    localparam int PROB_BITS   = 16;

    localparam int CNT_W  = $clog2(MAX_SAMPLES) + 1;
    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int WIN_W  = $clog2(MAX_WINDOWS);
    localparam int CLS_W  = $clog2(MAX_CLASSES);
    localparam int PROB_W = PROB_BITS + 1;
    localparam int HIT_W  = WIN_W + 1;
    localparam int SUM_W  = PROB_W + WIN_W;
    localparam int WL_W   = 7;
    localparam int CC_W   = 5;
    localparam int K_W    = 6;
    localparam int WL_MAX = 64;
    localparam int DIVD_W = SUM_W;
    localparam int DIVS_W = HIT_W;
    localparam int DCNT_W = $clog2(DIVD_W);

    localparam logic [PROB_W-1:0] ONE_Q  = PROB_W'(1) << PROB_BITS;
    localparam logic [PROB_W-1:0] HALF_Q = PROB_W'(1) << (PROB_BITS - 1);

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic REG_WINDOW_LEN  = 1'b0;
    localparam logic REG_CLASS_COUNT = 1'b1;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_LDIV   = 11'b000_0000_0010,
        S_LOAD   = 11'b000_0000_0100,
        S_QDIV   = 11'b000_0000_1000,
        S_QRD    = 11'b000_0001_0000,
        S_QMUL   = 11'b000_0010_0000,
        S_QACC   = 11'b000_0100_0000,
        S_OSTART = 11'b000_1000_0000,
        S_ODIV   = 11'b001_0000_0000,
        S_OWAIT  = 11'b010_0000_0000,
        S_SPARE  = 11'b100_0000_0000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage
`default_nettype wire

[rtl/core/swcl_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module swcl_div
    import swcl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [DIVS_W-1:0] divisor,
    output div_stat_t              stat,
    output logic      [DIVD_W-1:0] quotient,
    output logic      [DIVS_W-1:0] remainder
);

    logic [DIVD_W-1:0] quo_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              ge;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DCNT_W'(DIVD_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            quo_reg <= {quo_reg[DIVD_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

[rtl/core/swcl_fmul.sv]
// Factor select and rounded Q1.16 product step.
`default_nettype none
module swcl_fmul
    import swcl_pkg::*;
(
    input  wire logic [PROB_W-1:0] acc,
    input  wire logic [PROB_W-1:0] prob,
    input  wire logic              fired,
    output logic      [PROB_W-1:0] acc_out,
    output logic                   zero_err
);

    logic [PROB_W-1:0]     p_sat;
    logic [PROB_W-1:0]     factor;
    logic [2*PROB_W-1:0]   prod;

    always_comb
    begin
        p_sat = (prob > ONE_Q) ? ONE_Q : prob;
        if (fired)
        begin
            factor = (p_sat == '0) ? PROB_W'(1) : p_sat;
        end
        else
        begin
            factor = ONE_Q - p_sat;
        end
        zero_err = !fired && (factor == '0);
        prod     = acc * factor + {{PROB_W{1'b0}}, HALF_Q};
        acc_out  = prod[PROB_BITS +: PROB_W];
    end

endmodule
`default_nettype wire

[rtl/core/spike_window_class_likelihood.sv]
// Top level: sample row stores, query sequencer and per-class averaging.
//
//  channel | dir | beat contents
//  s_axis  | in  | tdata: opcode, prob, fired, window_class, query_window
//  m_axis  | out | tdata: class_index, average; tuser: empty_class, error; tlast
//  cfg     | in  | cfg_index, cfg_data; always ready
//
// Load: after a window_len change the first load runs a divide of the sample
//   count first. Query: always starts with that divide, then a read and
//   multiply step for each sample of every window, then per class with hits
//   a divide in the shared divider, plus the output handshake. Throughput is
//   set by the single multiplier step and the serial divider.
// Reset clears control state only; row stores hold undefined data until loaded.
// s_tready is low for the whole query, including while m_tvalid waits.
`default_nettype none
module spike_window_class_likelihood
    import swcl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // opcode, prob, fired, window_class, query_window
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // class_index, average, zero pad
    output logic      [1:0]  m_tuser,   // empty_class, zero_factor_error
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_data
);

    state_t state_reg;

    logic [WL_W-1:0]   wl_reg;
    logic [CC_W-1:0]   cc_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [K_W-1:0]    pos_reg;
    logic [CNT_W-1:0]  win_reg;
    logic              stale_reg;

    logic [PROB_W-1:0] lat_prob_reg;
    logic              lat_fired_reg;
    logic [CLS_W-1:0]  lat_cls_reg;
    logic [WIN_W-1:0]  lat_q_reg;

    logic [PROB_W-1:0] prob_mem [MAX_SAMPLES];
    logic              fired_mem [MAX_SAMPLES];
    logic [CLS_W-1:0]  class_mem [MAX_WINDOWS];
    logic [PROB_W-1:0] prob_rd_reg;
    logic              fired_rd_reg;
    logic [CLS_W-1:0]  cls_rd_reg;

    logic [ADDR_W-1:0] paddr_reg;
    logic [ADDR_W-1:0] faddr_reg;
    logic [ADDR_W-1:0] qbase_reg;
    logic [HIT_W-1:0]  nwin_reg;
    logic [HIT_W-1:0]  w_reg;
    logic [K_W-1:0]    k_reg;
    logic [PROB_W-1:0] acc_reg;
    logic              err_reg;
    logic [CLS_W-1:0]  c_reg;

    logic [SUM_W-1:0]  sum_reg [MAX_CLASSES];
    logic [HIT_W-1:0]  hits_reg [MAX_CLASSES];
    logic [MAX_CLASSES-1:0] hv_reg;

    logic [PROB_W-1:0] avg_reg;
    logic              empty_reg;

    logic [WL_W-1:0]   wl_eff;
    logic [CC_W-1:0]   nc_eff;
    logic              accept;
    logic [1:0]        in_op;
    logic [PROB_W-1:0] in_prob;
    logic              in_fired;
    logic [CLS_W-1:0]  in_cls;
    logic [WIN_W-1:0]  in_q;
    logic              ld_en;
    logic              ld_ok;
    logic [PROB_W-1:0] ld_prob_raw;
    logic [PROB_W-1:0] ld_prob;
    logic              ld_fired;
    logic [CLS_W-1:0]  ld_cls;

    logic [CLS_W-1:0]  hidx;
    logic              h_valid;
    logic [SUM_W-1:0]  cur_sum;
    logic [HIT_W-1:0]  cur_hits;

    logic              div_start;
    logic [DIVD_W-1:0] div_dividend;
    logic [DIVS_W-1:0] div_divisor;
    div_stat_t         div_stat;
    logic [DIVD_W-1:0] div_quo;
    logic [DIVS_W-1:0] div_rem;
    logic [HIT_W-1:0]  nwin_calc;
    logic [WIN_W+WL_W-1:0] qbase_calc;

    logic [PROB_W-1:0] mul_acc;
    logic              mul_err;

    assign wl_eff = (wl_reg == '0) ? WL_W'(1) :
                    (wl_reg > WL_W'(WL_MAX)) ? WL_W'(WL_MAX) : wl_reg;
    assign nc_eff = (cc_reg == '0) ? CC_W'(1) :
                    (cc_reg > CC_W'(MAX_CLASSES)) ? CC_W'(MAX_CLASSES) : cc_reg;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    assign in_op    = s_tdata[1:0];
    assign in_prob  = s_tdata[18:2];
    assign in_fired = s_tdata[19];
    assign in_cls   = s_tdata[23:20];
    assign in_q     = s_tdata[31:24];

    assign ld_en       = (accept && in_op == OP_LOAD && !stale_reg) || (state_reg == S_LOAD);
    assign ld_prob_raw = (state_reg == S_LOAD) ? lat_prob_reg : in_prob;
    assign ld_fired    = (state_reg == S_LOAD) ? lat_fired_reg : in_fired;
    assign ld_cls      = (state_reg == S_LOAD) ? lat_cls_reg : in_cls;
    assign ld_prob     = (ld_prob_raw > ONE_Q) ? ONE_Q : ld_prob_raw;
    assign ld_ok       = ld_en && (count_reg < CNT_W'(MAX_SAMPLES));

    assign hidx     = (state_reg == S_QACC) ? cls_rd_reg : c_reg;
    assign h_valid  = hv_reg[hidx];
    assign cur_sum  = h_valid ? sum_reg[hidx] : '0;
    assign cur_hits = h_valid ? hits_reg[hidx] : '0;

    assign div_start = (accept && ((in_op == OP_LOAD && stale_reg) || in_op == OP_QUERY))
                    || (state_reg == S_OSTART && h_valid);
    assign div_dividend = (state_reg == S_IDLE) ? DIVD_W'(count_reg)
                        : cur_sum + DIVD_W'(cur_hits >> 1);
    assign div_divisor  = (state_reg == S_IDLE) ? DIVS_W'(wl_eff) : cur_hits;

    assign nwin_calc  = (div_quo > DIVD_W'(MAX_WINDOWS)) ? HIT_W'(MAX_WINDOWS)
                      : div_quo[HIT_W-1:0];
    assign qbase_calc = lat_q_reg * wl_eff;

    swcl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    swcl_fmul u_fmul (
        .acc      (acc_reg),
        .prob     (prob_rd_reg),
        .fired    (fired_rd_reg),
        .acc_out  (mul_acc),
        .zero_err (mul_err)
    );

    always_ff @(posedge clk)
    begin
        if (ld_ok)
        begin
            prob_mem[count_reg[ADDR_W-1:0]]  <= ld_prob;
            fired_mem[count_reg[ADDR_W-1:0]] <= ld_fired;
            if (pos_reg == '0 && win_reg < CNT_W'(MAX_WINDOWS))
            begin
                class_mem[win_reg[WIN_W-1:0]] <= ld_cls;
            end
        end
        prob_rd_reg  <= prob_mem[paddr_reg];
        fired_rd_reg <= fired_mem[faddr_reg];
        cls_rd_reg   <= class_mem[w_reg[WIN_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg <= WL_W'(4);
            cc_reg <= CC_W'(2);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WINDOW_LEN:  wl_reg <= cfg_data;
                REG_CLASS_COUNT: cc_reg <= cfg_data[CC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lat_prob_reg  <= in_prob;
            lat_fired_reg <= in_fired;
            lat_cls_reg   <= in_cls;
            lat_q_reg     <= in_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_QACC && {1'b0, cls_rd_reg} < nc_eff)
        begin
            sum_reg[cls_rd_reg]  <= cur_sum + SUM_W'(acc_reg);
            hits_reg[cls_rd_reg] <= cur_hits + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pos_reg   <= '0;
            win_reg   <= '0;
            stale_reg <= 1'b0;
            hv_reg    <= '0;
            paddr_reg <= '0;
            faddr_reg <= '0;
            qbase_reg <= '0;
            nwin_reg  <= '0;
            w_reg     <= '0;
            k_reg     <= '0;
            acc_reg   <= '0;
            err_reg   <= 1'b0;
            c_reg     <= '0;
            avg_reg   <= '0;
            empty_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == REG_WINDOW_LEN)
            begin
                stale_reg <= 1'b1;
            end
            if (ld_ok)
            begin
                count_reg <= count_reg + 1'b1;
                if ({1'b0, pos_reg} == wl_eff - 1'b1)
                begin
                    pos_reg <= '0;
                    win_reg <= win_reg + 1'b1;
                end
                else
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (in_op == OP_LOAD && stale_reg)
                        begin
                            state_reg <= S_LDIV;
                        end
                        else if (in_op == OP_QUERY)
                        begin
                            state_reg <= S_QDIV;
                        end
                        else if (in_op == OP_CLEAR)
                        begin
                            count_reg <= '0;
                            pos_reg   <= '0;
                            win_reg   <= '0;
                            stale_reg <= 1'b0;
                        end
                    end
                end
                S_LDIV:
                begin
                    if (div_stat.done)
                    begin
                        pos_reg   <= div_rem[K_W-1:0];
                        win_reg   <= div_quo[CNT_W-1:0];
                        stale_reg <= 1'b0;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    state_reg <= S_IDLE;
                end
                S_QDIV:
                begin
                    if (div_stat.done)
                    begin
                        pos_reg   <= div_rem[K_W-1:0];
                        win_reg   <= div_quo[CNT_W-1:0];
                        stale_reg <= 1'b0;
                        nwin_reg  <= nwin_calc;
                        if ({1'b0, lat_q_reg} >= nwin_calc)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            paddr_reg <= '0;
                            faddr_reg <= qbase_calc[ADDR_W-1:0];
                            qbase_reg <= qbase_calc[ADDR_W-1:0];
                            w_reg     <= '0;
                            k_reg     <= '0;
                            acc_reg   <= ONE_Q;
                            err_reg   <= 1'b0;
                            hv_reg    <= '0;
                            state_reg <= S_QRD;
                        end
                    end
                end
                S_QRD:
                begin
                    state_reg <= S_QMUL;
                end
                S_QMUL:
                begin
                    acc_reg   <= mul_acc;
                    err_reg   <= err_reg | mul_err;
                    paddr_reg <= paddr_reg + 1'b1;
                    faddr_reg <= faddr_reg + 1'b1;
                    if ({1'b0, k_reg} == wl_eff - 1'b1)
                    begin
                        state_reg <= S_QACC;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_QRD;
                    end
                end
                S_QACC:
                begin
                    if ({1'b0, cls_rd_reg} < nc_eff)
                    begin
                        hv_reg[cls_rd_reg] <= 1'b1;
                    end
                    w_reg <= w_reg + 1'b1;
                    if (w_reg + 1'b1 == nwin_reg)
                    begin
                        c_reg     <= '0;
                        state_reg <= S_OSTART;
                    end
                    else
                    begin
                        k_reg     <= '0;
                        acc_reg   <= ONE_Q;
                        faddr_reg <= qbase_reg;
                        state_reg <= S_QRD;
                    end
                end
                S_OSTART:
                begin
                    if (h_valid)
                    begin
                        state_reg <= S_ODIV;
                    end
                    else
                    begin
                        avg_reg   <= '0;
                        empty_reg <= 1'b1;
                        state_reg <= S_OWAIT;
                    end
                end
                S_ODIV:
                begin
                    if (div_stat.done)
                    begin
                        avg_reg   <= div_quo[PROB_W-1:0];
                        empty_reg <= 1'b0;
                        state_reg <= S_OWAIT;
                    end
                end
                S_OWAIT:
                begin
                    if (m_tready)
                    begin
                        if ({1'b0, c_reg} == nc_eff - 1'b1)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            c_reg     <= c_reg + 1'b1;
                            state_reg <= S_OSTART;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = (state_reg == S_OWAIT);
    assign m_tdata  = {3'b000, avg_reg, c_reg};
    assign m_tuser  = {err_reg, empty_reg};
    assign m_tlast  = ({1'b0, c_reg} == nc_eff - 1'b1);

endmodule
`default_nettype wire

[rtl/core/swcl_check.sv]
// Port-level checker for the spike window class likelihood block, with bind.
`default_nettype none
module swcl_check
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a result waits");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
        else $error("block not back to idle after final class");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23:21] == 3'b000)
                     && !(m_tdata[20] && (m_tdata[19:4] != 16'h0000)))
        else $error("average above one or padding set");

endmodule

bind spike_window_class_likelihood swcl_check u_swcl_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire
